// ----- src/kwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_pkg - shared types, constants and helpers for the keyed word checksum
// Holds the operation codes, the fold control struct and the constant-divisor
// remainder helpers used by the top level.
// ----------------------------------------------------------------------------
package kwc_pkg;

   localparam int WORD_W   = 32;
   localparam int KEY_W    = 16;
   localparam int INDEX_W  = 4;
   localparam int PHASE_W  = 2;
   localparam int SHAMT_W  = 4;   // word mod 11 lies in 0..10
   localparam int SCR_W    = 5;   // index + 3 lies in 3..18

   localparam int SEED_SHIFT    = 9;
   localparam int SHIFT_MOD     = 11;
   localparam int SCRAMBLE_BASE = 3;

   // Reciprocal of 11 for values up to 1026: q = (x * 745) >> 13
   localparam int MOD11_RECIP  = 745;
   localparam int MOD11_RSHIFT = 13;

   typedef enum logic [PHASE_W-1:0] {
      OP_XOR       = 2'd0,
      OP_ADD       = 2'd1,
      OP_SHIFT_XOR = 2'd2
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [INDEX_W-1:0]   index;
   } fold_ctl_type;

   // Remainder of a 32-bit word by 11. Uses 2^10 mod 11 == 1 to fold the
   // word into 10-bit chunks, then a reciprocal multiply on the small value.
   function automatic logic [SHAMT_W-1:0] word_mod11(input logic [WORD_W-1:0] w);
      logic [11:0] c;
      logic [10:0] d;
      logic [20:0] p;
      logic [6:0]  q;
      logic [10:0] r;
      c = 12'(w[9:0]) + 12'(w[19:10]) + 12'(w[29:20]) + 12'(w[31:30]);
      d = 11'(c[9:0]) + 11'(c[11:10]);
      p = 21'(d) * 21'(MOD11_RECIP);
      q = p[MOD11_RSHIFT +: 7];
      r = d - 11'(q) * 11'(SHIFT_MOD);
      return r[SHAMT_W-1:0];
   endfunction

   // Remainder of a 16-bit key by 3, using 4 mod 3 == 1.
   function automatic logic [PHASE_W-1:0] key_mod3(input logic [KEY_W-1:0] k);
      logic [4:0] s;
      logic [2:0] t;
      logic [2:0] u;
      s = '0;
      for (int i = 0; i < KEY_W / 2; i++) begin
         s = s + 5'(k[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      u = 3'(t[1:0]) + 3'(t[2]);
      if (u >= 3'd3) begin
         u = u - 3'd3;
      end
      return u[PHASE_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] seed_of(input logic [KEY_W-1:0] k);
      return WORD_W'(k) << SEED_SHIFT;
   endfunction

endpackage

// ----- src/keyed_word_checksum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_word_checksum - keyed 32-bit checksum over a word stream
// Folds message words into a keyed accumulator and emits the checksum on the
// transaction marked last.
// ----------------------------------------------------------------------------
// The block takes one request transaction per clock while req_ready is high
// and returns one response transaction for every request marked last. Each
// request passes an input stage (where word mod 11 is precomputed) and is
// folded into the accumulator as it leaves; a last one also fills the response
// register, so it waits while that register is full. The word rate is set by
// the accumulator loop through the fold logic. A request with word_valid low
// is ignored, or with last set only marks the end of the message (for an
// empty message the checksum is key << 9). Writing the key restarts the
// message in progress; write it only while no transaction is in flight.
// ----------------------------------------------------------------------------
module keyed_word_checksum (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [kwc_pkg::WORD_W-1:0]  req_word,
   input  logic                        req_word_valid,
   input  logic                        req_last,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [kwc_pkg::WORD_W-1:0]  rsp_checksum,
   // key register
   input  logic                        csr_we,
   input  logic [kwc_pkg::KEY_W-1:0]   csr_wdata
);

   // Input stage
   logic                         s1_valid_ff,  s1_valid_in;
   logic [kwc_pkg::WORD_W-1:0]   s1_word_ff;
   logic                         s1_wvalid_ff;
   logic                         s1_last_ff;
   logic [kwc_pkg::SHAMT_W-1:0]  s1_shamt_ff;

   // Checksum state
   logic [kwc_pkg::KEY_W-1:0]    key_ff,   key_in;
   logic [kwc_pkg::WORD_W-1:0]   acc_ff,   acc_in;
   logic [kwc_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic [kwc_pkg::INDEX_W-1:0]  index_ff, index_in;

   // Response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [kwc_pkg::WORD_W-1:0]   rsp_sum_ff;

   logic                         req_fire;
   logic                         s1_advance;
   logic [kwc_pkg::WORD_W-1:0]   fold_acc;
   logic [kwc_pkg::WORD_W-1:0]   acc_step;
   kwc_pkg::fold_ctl_type        fold_ctl;

   // A last transaction may leave the input stage only when the response
   // register is free or being emptied in this cycle.
   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_fire   = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Map phase to operation; phase 3 is never held and falls to XOR.
   always_comb begin
      unique case (phase_ff)
         2'd1:    fold_ctl.op = kwc_pkg::OP_ADD;
         2'd2:    fold_ctl.op = kwc_pkg::OP_SHIFT_XOR;
         default: fold_ctl.op = kwc_pkg::OP_XOR;
      endcase
      fold_ctl.index = index_ff;
   end

   kwc_fold u_fold (
      .acc      (acc_ff),
      .word     (s1_word_ff),
      .shamt    (s1_shamt_ff),
      .key      (key_ff),
      .ctl      (fold_ctl),
      .acc_next (fold_acc)
   );

   // Accumulator after this transaction's word, if it carries one
   assign acc_step = s1_wvalid_ff ? fold_acc : acc_ff;

   always_comb begin
      key_in   = key_ff;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      index_in = index_ff;
      if (csr_we) begin
         // New key: restart the message from its seed
         key_in   = csr_wdata;
         acc_in   = kwc_pkg::seed_of(csr_wdata);
         phase_in = kwc_pkg::key_mod3(csr_wdata);
         index_in = '0;
      end else if (s1_advance) begin
         if (s1_last_ff) begin
            acc_in   = kwc_pkg::seed_of(key_ff);
            phase_in = kwc_pkg::key_mod3(key_ff);
            index_in = '0;
         end else if (s1_wvalid_ff) begin
            acc_in   = fold_acc;
            phase_in = (phase_ff >= 2'd2) ? 2'd0 : phase_ff + 2'd1;
            index_in = index_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         key_ff       <= '0;
         acc_ff       <= '0;
         phase_ff     <= '0;
         index_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         key_ff       <= key_in;
         acc_ff       <= acc_in;
         phase_ff     <= phase_in;
         index_ff     <= index_in;
      end
   end

   // Payload: hold until the next transaction is taken
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_word_ff   <= req_word;
         s1_wvalid_ff <= req_word_valid;
         s1_last_ff   <= req_last;
         s1_shamt_ff  <= kwc_pkg::word_mod11(req_word);
      end
      if (s1_advance && s1_last_ff) begin
         rsp_sum_ff <= acc_step;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = rsp_sum_ff;

   // A stalled input transaction is never dropped
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff)
      else $error("input stage transaction lost while stalled");

   // A last transaction leaving the input stage fills the response register
   a_rsp_fill: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_last_ff |=> rsp_valid_ff)
      else $error("last transaction produced no response");

   // A key write restarts the accumulator at its seed
   a_key_seed: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> acc_ff == kwc_pkg::seed_of($past(csr_wdata)) && index_ff == '0)
      else $error("key write did not restart the checksum");

   // Each folded non-last word advances the word index by one
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_wvalid_ff && !s1_last_ff && !csr_we
      |=> index_ff == $past(index_ff) + 1'b1)
      else $error("word index did not advance");

   // The operation phase never holds the unused code
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("operation phase out of range");

endmodule

// ----- src/kwc_fold.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_fold - one word fold of the keyed checksum
// Applies the phase-selected operation to the accumulator and then the
// index-dependent scramble.
// ----------------------------------------------------------------------------
module kwc_fold (
   input  logic [kwc_pkg::WORD_W-1:0]  acc,
   input  logic [kwc_pkg::WORD_W-1:0]  word,
   input  logic [kwc_pkg::SHAMT_W-1:0] shamt,
   input  logic [kwc_pkg::KEY_W-1:0]   key,
   input  kwc_pkg::fold_ctl_type       ctl,
   output logic [kwc_pkg::WORD_W-1:0]  acc_next
);

   logic [kwc_pkg::WORD_W-1:0] op_res;
   logic [kwc_pkg::WORD_W-1:0] mix_sum;
   logic [kwc_pkg::SCR_W-1:0]  scr_sh;

   always_comb begin
      case (ctl.op)
         kwc_pkg::OP_ADD:       op_res = acc + word;
         kwc_pkg::OP_SHIFT_XOR: op_res = (acc << shamt) ^ word;
         default:               op_res = acc ^ word;
      endcase
   end

   assign scr_sh   = kwc_pkg::SCR_W'(ctl.index) + kwc_pkg::SCR_W'(kwc_pkg::SCRAMBLE_BASE);
   assign mix_sum  = op_res + kwc_pkg::WORD_W'(key);
   assign acc_next = op_res ^ (mix_sum >> scr_sh);

endmodule

// ----- tb/tb_keyed_word_checksum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_word_checksum - self-checking testbench for the keyed checksum
// Drives word transactions with random gaps, models the keyed fold in a
// scoreboard class and compares every returned checksum in order. Sweeps the
// key across its extremes, restarts a message by a key write and holds the
// response side off long enough to stall the request side.
// ----------------------------------------------------------------------------
module tb_keyed_word_checksum;

   localparam int DRAIN_CYCLES  = 6;     // drain wait after the last checksum
   localparam int HOLD_CYCLES   = 80;    // long response hold-off
   localparam int WATCHDOG_MAX  = 2000;  // cycles with no transaction at all
   localparam int PHASE_ITEMS   = 68;    // random items per key setting
   localparam int QUIET_AFTER   = 330;   // random items before gaps stop

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the key and fold state, queue of checksums due
   // -------------------------------------------------------------------------
   class checksum_scoreboard;
      logic [kwc_pkg::KEY_W-1:0]    key;
      logic [kwc_pkg::WORD_W-1:0]   acc;
      kwc_pkg::op_type              phase;
      logic [kwc_pkg::INDEX_W-1:0]  index;
      logic [kwc_pkg::WORD_W-1:0]   checksums_due[$];
      int                           errors;

      function new();
         key    = '0;
         errors = 0;
         restart();
      endfunction

      function void restart();
         acc   = kwc_pkg::WORD_W'(key) << kwc_pkg::SEED_SHIFT;
         phase = kwc_pkg::op_type'(key % 3);
         index = '0;
      endfunction

      function void load_key(input logic [kwc_pkg::KEY_W-1:0] k);
         key = k;
         restart();
      endfunction

      // Fold one accepted request transaction, queue a checksum on last.
      function void note_request(input logic [kwc_pkg::WORD_W-1:0] w, input logic wv,
                                 input logic last);
         int unsigned sh;
         if (wv) begin
            case (phase)
               kwc_pkg::OP_ADD: begin
                  acc = acc + w;
               end
               kwc_pkg::OP_SHIFT_XOR: begin
                  sh  = w % kwc_pkg::SHIFT_MOD;
                  acc = (acc << sh) ^ w;
               end
               default: begin
                  acc = acc ^ w;
               end
            endcase
            sh    = int'(index) + kwc_pkg::SCRAMBLE_BASE;
            acc   = acc ^ ((acc + kwc_pkg::WORD_W'(key)) >> sh);
            phase = (phase == kwc_pkg::OP_SHIFT_XOR) ? kwc_pkg::OP_XOR
                                                     : kwc_pkg::op_type'(phase + 1);
            index = index + 1'b1;
         end
         if (last) begin
            checksums_due.push_back(acc);
            restart();
         end
      endfunction

      function void check_checksum(input logic [kwc_pkg::WORD_W-1:0] actual);
         logic [kwc_pkg::WORD_W-1:0] expected;
         if (checksums_due.size() == 0) begin
            $display("%0t: unexpected checksum %08h", $time, actual);
            errors++;
         end else begin
            expected = checksums_due.pop_front();
            if (actual !== expected) begin
               $display("%0t: checksum mismatch, expected %08h actual %08h",
                        $time, expected, actual);
               errors++;
            end
         end
      endfunction

      function int pending();
         return checksums_due.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, DUT
   // -------------------------------------------------------------------------
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [kwc_pkg::WORD_W-1:0]  req_word = '0;
   logic                        req_word_valid = 1'b0;
   logic                        req_last = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [kwc_pkg::WORD_W-1:0]  rsp_checksum;
   logic                        csr_we = 1'b0;
   logic [kwc_pkg::KEY_W-1:0]   csr_wdata = '0;

   checksum_scoreboard sb = new();

   bit quiet       = 1'b0;   // no idling on either side once set
   bit hold_off_go = 1'b0;   // asks the response side for a long hold-off
   int items_sent  = 0;      // random items accepted so far

   always #5 clock = ~clock;

   keyed_word_checksum dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word       (req_word),
      .req_word_valid (req_word_valid),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_checksum   (rsp_checksum),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Response side: check each transaction, stall in short bursts, and honor
   // a long hold-off request counted here.
   // -------------------------------------------------------------------------
   int hold_left  = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_checksum(rsp_checksum);
      end
      if (hold_off_go) begin
         hold_off_go = 1'b0;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         // this cycle is the first of the burst
         stall_left = $urandom_range(1, 3) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run when nothing moves for too long
   // -------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side tasks. Every task is entered right after a rising edge.
   // -------------------------------------------------------------------------

   // Offer one request transaction and hold it until accepted.
   task automatic send_request(input logic [kwc_pkg::WORD_W-1:0] w, input logic wv,
                               input logic last);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_word       <= w;
      req_word_valid <= wv;
      req_last       <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_request(w, wv, last);
   endtask

   // Drop valid, wait for every checksum due, then let the pipeline drain.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the key; call only while the block is idle.
   task automatic write_key(input logic [kwc_pkg::KEY_W-1:0] k);
      csr_we    <= 1'b1;
      csr_wdata <= k;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.load_key(k);
   endtask

   // Mix of full random words, extremes and small values so that every shift
   // amount of the shift-xor operation shows up often.
   function automatic logic [kwc_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return kwc_pkg::WORD_W'($urandom_range(0, 21));
         3:       return {1'b1, 31'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // One message: mostly words, sometimes an idle transaction in between, and
   // ended either by a last word or by an empty terminator.
   task automatic send_random_message();
      int  n_words;
      bit  empty_end;
      case ($urandom_range(0, 7))
         0:       n_words = 0;
         1:       n_words = $urandom_range(17, 40);   // wrap the word index
         default: n_words = $urandom_range(1, 6);
      endcase
      empty_end = (n_words == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n_words; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            send_request($urandom, 1'b0, 1'b0);
         end
         send_request(pick_word(), 1'b1, (i == n_words - 1) && !empty_end);
         items_sent++;
      end
      if (empty_end) begin
         send_request($urandom, 1'b0, 1'b1);
         items_sent++;
      end
      if (items_sent >= QUIET_AFTER) begin
         quiet = 1'b1;
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   logic [kwc_pkg::KEY_W-1:0] phase_keys[6];

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, key at its reset value of zero.
      send_request(32'h1234_5678, 1'b0, 1'b1);          // empty message
      send_request(32'hDEAD_BEEF, 1'b0, 1'b0);          // idle, ignored
      send_request(32'hFFFF_FFFF, 1'b1, 1'b0);          // xor
      send_request(32'h0000_0000, 1'b1, 1'b0);          // add
      send_request(32'hAAAA_AAAA, 1'b1, 1'b0);          // shift then xor
      send_request(32'h5555_5555, 1'b1, 1'b1);
      send_request(32'h8000_0000, 1'b1, 1'b0);
      send_request(32'h0000_0000, 1'b0, 1'b0);          // idle mid message
      send_request(32'h0000_000A, 1'b1, 1'b0);          // largest shift amount, folded by add
      send_request(32'h7FFF_FFFF, 1'b1, 1'b0);
      send_request(32'h0000_0000, 1'b0, 1'b1);          // empty terminator

      // Restart a message in progress by writing the key.
      send_request(32'hCAFE_F00D, 1'b1, 1'b0);
      send_request(32'h0BAD_C0DE, 1'b1, 1'b0);
      settle();
      write_key(16'hFFFF);
      send_request(32'h0000_0000, 1'b0, 1'b1);          // seed of the new key
      send_request(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_request(32'h0000_0001, 1'b1, 1'b0);
      send_request(32'hFFFF_FFFE, 1'b1, 1'b1);

      // Random part over several key settings, extremes included.
      phase_keys[0] = 16'h0001;
      phase_keys[1] = 16'h0002;
      phase_keys[2] = 16'($urandom);
      phase_keys[3] = 16'hFFFF;
      phase_keys[4] = 16'($urandom);
      phase_keys[5] = 16'h0000;
      for (int p = 0; p < 6; p++) begin
         settle();
         write_key(phase_keys[p]);
         if (p == 1) begin
            // keep offering while the response side holds off: fill the block
            hold_off_go = 1'b1;
         end
         while (items_sent < (p + 1) * PHASE_ITEMS) begin
            send_random_message();
         end
      end

      settle();
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
